@@ rtl/gft_pkg.sv @@
// gft_pkg: shared types, codes and keyword tables for the grammar file tokenizer.
// Used by grammar_file_tokenizer and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gft_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;
	localparam int unsigned LINE_BITS_DEF   = 24;

	localparam int unsigned KIND_W = 5;
	localparam int unsigned ERR_W  = 2;
	localparam int unsigned CFG_DW = 32;
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned MAXLEN_W = 16;

	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 16'd50000;

	// register index, taken from paddr[2]
	localparam logic REG_DROP_LAYOUT   = 1'b0;
	localparam logic REG_MAX_TOKEN_LEN = 1'b1;

	// result queue
	localparam int unsigned RQ_DEPTH = 4;

	typedef enum logic [3:0] {
		MODE_IDLE       = 4'd0,
		MODE_BLANK      = 4'd1,
		MODE_SLASH      = 4'd2,
		MODE_BLOCK      = 4'd3,
		MODE_BLOCK_STAR = 4'd4,
		MODE_LINE       = 4'd5,
		MODE_PERCENT    = 4'd6,
		MODE_WORD       = 4'd7,
		MODE_DOLLAR     = 4'd8,
		MODE_QUOTE      = 4'd9,
		MODE_QUOTE_ESC  = 4'd10
	} lex_mode_t;

	localparam logic [KIND_W-1:0] KIND_SPACE    = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NEWLINE  = 5'd1;
	localparam logic [KIND_W-1:0] KIND_COMMENT  = 5'd2;
	localparam logic [KIND_W-1:0] KIND_NAME     = 5'd3;
	localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd4;
	localparam logic [KIND_W-1:0] KIND_QUOTED   = 5'd5;
	localparam logic [KIND_W-1:0] KIND_SINGLE   = 5'd6;
	localparam logic [KIND_W-1:0] KIND_MARK     = 5'd7;
	localparam logic [KIND_W-1:0] KIND_LCURL    = 5'd8;
	localparam logic [KIND_W-1:0] KIND_RCURL    = 5'd9;
	localparam logic [KIND_W-1:0] KIND_END      = 5'd20;
	localparam logic [KIND_W-1:0] KIND_DOLLAR   = 5'd21;

	localparam logic [ERR_W-1:0] ERR_NONE         = 2'd0;
	localparam logic [ERR_W-1:0] ERR_TOO_LONG     = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OPEN_COMMENT = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OPEN_QUOTE   = 2'd3;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_LCURL  = 8'h7B;
	localparam logic [7:0] CH_RCURL  = 8'h7D;

	// percent keywords, text without the percent sign, right-justified
	localparam int unsigned KW_COUNT     = 11;
	localparam int unsigned KW_CHARS     = 11;
	localparam int unsigned KW_CAND_W    = 14;
	localparam logic [KW_CAND_W-1:0] KW_CAND_RESET = '1;

	localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
		"token", "term", "left", "right", "nonassoc", "prec",
		"type", "union", "start", "expect", "pure_parser"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd11
	};
	localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
		5'd10, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
	};

	function automatic logic is_blank(input logic [7:0] b);
		return b inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_US};
	endfunction

	// character of keyword i at position p, zero past its end
	function automatic logic [7:0] kw_byte(input int unsigned i, input logic [3:0] p);
		int unsigned n;
		n = 32'(KW_LEN[i]);
		if (32'(p) < n)
			return KW_TEXT[i][(n - 1 - 32'(p)) * 8 +: 8];
		return 8'h00;
	endfunction

	function automatic logic [KIND_W-1:0] word_kind(
		input logic [7:0]           fc,
		input logic [KW_CAND_W-1:0] cand,
		input logic [3:0]           pos
	);
		logic [KIND_W-1:0] k;
		k = KIND_NAME;
		if (fc == CH_PCT) begin
			for (int i = KW_COUNT - 1; i >= 0; i--)
				if (cand[i] && KW_LEN[i] == pos)
					k = KW_KIND[i];
		end else if (is_digit(fc)) begin
			k = KIND_NUMBER;
		end
		return k;
	endfunction

endpackage

`default_nettype wire

@@ rtl/grammar_file_tokenizer.sv @@
// grammar_file_tokenizer: byte-stream lexer for grammar files with a small result queue.
// Depends on gft_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input stream s_*: one word per source byte, s_tdata = in_byte, s_tuser = end_of_input.
//   An end word flushes the open token and returns an end token (kind 20).
//   Output stream m_*: one word per token, m_tlast marks the final token of an input word.
//   Config: APB, reg 0 (addr 0) drop_layout, reg 1 (addr 4) max_token_len. Write while idle.
// Timing:
//   An accepted word is held in the input register until the result queue has room; then the
//   lexer state and the result queue update together, and the queue presents the output word.
//   Sustained rate is one input word per cycle while the queue has room. A byte that closes
//   one token and is itself a one-byte token (and an end word after an open token) yields
//   two output words, which drain through the 4-entry result queue at one per cycle while
//   m_tready is high. s_tready is low while the input register is full and the queue holds
//   3 or more words, so a stalled receiver backs up the input after at most a few words.
// Reset:
//   arst_n clears the lexer to idle, line count to 0, config to its defaults and empties
//   the queue.
module grammar_file_tokenizer
	import gft_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
	localparam int unsigned FIELD_W = KIND_W + 8 + LENGTH_BITS + LINE_BITS + ERR_W,
	localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // in_byte
	input  wire logic               s_tuser,   // end_of_input

	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // kind, lead_byte, token_length, start_line, error_code
	output logic                    m_tlast,   // last

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [CFG_AW-1:0]  paddr,
	input  wire logic [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0]       prdata,
	output logic                    pready
);

	localparam int unsigned RQ_AW = $clog2(RQ_DEPTH);
	localparam int unsigned CW    = RQ_AW + 1;
	localparam logic [32:0] LEN_MASK33 = (33'd1 << LENGTH_BITS) - 33'd1;

	typedef struct packed {
		logic                   last;
		logic [ERR_W-1:0]       err;
		logic [LINE_BITS-1:0]   line;
		logic [LENGTH_BITS-1:0] len;
		logic [7:0]             lead;
		logic [KIND_W-1:0]      kind;
	} res_t;

	// config
	logic                drop_q;
	logic [MAXLEN_W-1:0] max_len_q;
	logic                cfg_wr;

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       in_acc;
	logic       adv;

	// lexer state
	lex_mode_t              mode_q, mode_d;
	logic [7:0]             qc_q, qc_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_a, len_b;
	logic                   tlg_q, tlg_d, tlg_a, tlg_b;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [LINE_BITS-1:0]   tl_q, tl_d;
	logic [7:0]             fc_q, fc_d;
	logic [KW_CAND_W-1:0]   kc_q, kc_d;
	logic [3:0]             kp_q, kp_d;
	logic [LENGTH_BITS-1:0] limit;

	// step control
	logic             inc, go_idle, track, dp;
	logic             f1_v, f2_v;
	logic [KIND_W-1:0] f1_kind;
	logic [ERR_W-1:0]  f1_e;
	res_t             f1, f2, slot0, slot1;
	logic             e1, e2;
	logic [1:0]       push_n;

	// result queue
	res_t             rq_mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             pop;
	res_t             head;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q    <= 1'b0;
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DROP_LAYOUT:   drop_q    <= pwdata[0];
				REG_MAX_TOKEN_LEN: max_len_q <= pwdata[MAXLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DROP_LAYOUT:   prdata = CFG_DW'(drop_q);
			REG_MAX_TOKEN_LEN: prdata = CFG_DW'(max_len_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	assign adv      = v_s1 && (cnt_q <= CW'(RQ_DEPTH - 2));
	assign s_tready = !v_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_acc)
			v_s1 <= 1'b1;
		else if (adv)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
	end

	// ---------------- lexer step ----------------
	always_comb begin
		logic [32:0] max33;
		max33 = 33'(max_len_q);
		limit = LENGTH_BITS'((max33 < LEN_MASK33) ? max33 : LEN_MASK33);
		len_b = (limit != '0) ? LENGTH_BITS'(1) : '0;
		tlg_b = (limit == '0);
	end

	always_comb begin
		mode_d  = mode_q;
		qc_d    = qc_q;
		line_d  = line_q;
		tl_d    = tl_q;
		fc_d    = fc_q;
		kc_d    = kc_q;
		kp_d    = kp_q;
		inc     = 1'b0;
		go_idle = 1'b0;
		track   = 1'b0;
		dp      = 1'b0;
		f1_v    = 1'b0;
		f1_kind = KIND_SPACE;
		f1_e    = ERR_NONE;
		f2_v    = 1'b0;
		f2      = '0;

		if (eoi_s1) begin
			f1_v = 1'b1;
			case (mode_q)
				MODE_BLANK:   f1_kind = KIND_SPACE;
				MODE_SLASH:   f1_kind = KIND_SINGLE;
				MODE_BLOCK, MODE_BLOCK_STAR: begin
					f1_kind = KIND_COMMENT;
					f1_e    = ERR_OPEN_COMMENT;
				end
				MODE_LINE:    f1_kind = KIND_COMMENT;
				MODE_PERCENT: f1_kind = KIND_SINGLE;
				MODE_WORD:    f1_kind = word_kind(fc_q, kc_q, kp_q);
				MODE_DOLLAR:  f1_kind = KIND_DOLLAR;
				MODE_QUOTE, MODE_QUOTE_ESC: begin
					f1_kind = KIND_QUOTED;
					f1_e    = ERR_OPEN_QUOTE;
				end
				default:      f1_v = 1'b0;
			endcase
			f2_v      = 1'b1;
			f2.kind   = KIND_END;
			f2.line   = line_q;
			f2.err    = ERR_NONE;
			mode_d    = MODE_IDLE;
		end else begin
			case (mode_q)
				MODE_BLANK: begin
					if (is_blank(byte_s1)) begin
						inc = 1'b1;
					end else begin
						f1_v = 1'b1; f1_kind = KIND_SPACE; go_idle = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (byte_s1 == CH_STAR) begin
						inc = 1'b1; mode_d = MODE_BLOCK;
					end else if (byte_s1 == CH_SLASH) begin
						inc = 1'b1; mode_d = MODE_LINE;
					end else begin
						f1_v = 1'b1; f1_kind = KIND_SINGLE; go_idle = 1'b1;
					end
				end
				MODE_BLOCK: begin
					inc = 1'b1;
					if (byte_s1 == CH_STAR)
						mode_d = MODE_BLOCK_STAR;
				end
				MODE_BLOCK_STAR: begin
					inc = 1'b1;
					if (byte_s1 == CH_SLASH) begin
						f1_v = 1'b1; f1_kind = KIND_COMMENT; mode_d = MODE_IDLE;
					end else if (byte_s1 != CH_STAR) begin
						mode_d = MODE_BLOCK;
					end
				end
				MODE_LINE: begin
					inc = 1'b1;
					if (byte_s1 == CH_NL) begin
						f1_v = 1'b1; f1_kind = KIND_COMMENT; mode_d = MODE_IDLE;
					end
				end
				MODE_PERCENT: begin
					if (byte_s1 == CH_PCT || byte_s1 == CH_LCURL || byte_s1 == CH_RCURL) begin
						inc    = 1'b1;
						f1_v   = 1'b1;
						mode_d = MODE_IDLE;
						f1_kind = (byte_s1 == CH_PCT) ? KIND_MARK :
						          (byte_s1 == CH_LCURL) ? KIND_LCURL : KIND_RCURL;
					end else if (is_word(byte_s1)) begin
						inc = 1'b1; track = 1'b1; mode_d = MODE_WORD;
					end else begin
						f1_v = 1'b1; f1_kind = KIND_SINGLE; go_idle = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_word(byte_s1)) begin
						inc   = 1'b1;
						track = (fc_q == CH_PCT);
					end else begin
						f1_v = 1'b1; f1_kind = word_kind(fc_q, kc_q, kp_q); go_idle = 1'b1;
					end
				end
				MODE_DOLLAR: begin
					if (byte_s1 == CH_DOLLAR) begin
						f1_v = 1'b1; f1_kind = KIND_DOLLAR; go_idle = 1'b1; dp = 1'b1;
					end else if (is_word(byte_s1) && !is_digit(byte_s1)) begin
						inc = 1'b1; mode_d = MODE_WORD;
					end else begin
						f1_v = 1'b1; f1_kind = KIND_DOLLAR; go_idle = 1'b1;
					end
				end
				MODE_QUOTE: begin
					inc = 1'b1;
					if (byte_s1 == qc_q) begin
						f1_v = 1'b1; f1_kind = KIND_QUOTED; mode_d = MODE_IDLE;
					end else if (byte_s1 == CH_NL) begin
						f1_v = 1'b1; f1_kind = KIND_QUOTED; f1_e = ERR_OPEN_QUOTE;
						mode_d = MODE_IDLE;
					end else if (byte_s1 == CH_BSL) begin
						mode_d = MODE_QUOTE_ESC;
					end
				end
				MODE_QUOTE_ESC: begin
					inc = 1'b1; mode_d = MODE_QUOTE;
				end
				default: go_idle = 1'b1;
			endcase
			if (byte_s1 == CH_NL)
				line_d = line_q + LINE_BITS'(1);
		end

		// length of the open token
		len_a = len_q;
		tlg_a = tlg_q;
		if (inc) begin
			if (len_q < limit)
				len_a = len_q + LENGTH_BITS'(1);
			else
				tlg_a = 1'b1;
		end
		len_d = len_a;
		tlg_d = tlg_a;

		f1.kind = f1_kind;
		f1.lead = fc_q;
		f1.len  = len_a;
		f1.line = tl_q;
		f1.err  = (f1_e == ERR_NONE && tlg_a) ? ERR_TOO_LONG : f1_e;
		f1.last = 1'b0;

		if (track) begin
			for (int i = 0; i < KW_COUNT; i++)
				if (kp_q >= KW_LEN[i] || kw_byte(i, kp_q) != byte_s1)
					kc_d[i] = 1'b0;
			kp_d = (kp_q == 4'hF) ? kp_q : kp_q + 4'd1;
		end

		// start of a new token
		if (go_idle) begin
			fc_d    = byte_s1;
			tl_d    = line_q;
			len_d   = len_b;
			tlg_d   = tlg_b;
			kc_d    = KW_CAND_RESET;
			kp_d    = '0;
			mode_d  = MODE_IDLE;
			f2.lead = byte_s1;
			f2.len  = len_b;
			f2.line = line_q;
			f2.err  = tlg_b ? ERR_TOO_LONG : ERR_NONE;
			if (is_blank(byte_s1)) begin
				mode_d = MODE_BLANK;
			end else if (byte_s1 == CH_NL) begin
				f2_v = 1'b1; f2.kind = KIND_NEWLINE;
			end else if (byte_s1 == CH_SLASH) begin
				mode_d = MODE_SLASH;
			end else if (byte_s1 == CH_PCT) begin
				mode_d = MODE_PERCENT;
			end else if (byte_s1 == CH_DOLLAR) begin
				if (dp) begin
					f2_v = 1'b1; f2.kind = KIND_DOLLAR;
				end else begin
					mode_d = MODE_DOLLAR;
				end
			end else if (is_word(byte_s1)) begin
				mode_d = MODE_WORD;
			end else if (byte_s1 == CH_SQ || byte_s1 == CH_DQ) begin
				qc_d   = byte_s1;
				mode_d = MODE_QUOTE;
			end else begin
				f2_v = 1'b1; f2.kind = KIND_SINGLE;
			end
		end
		f2.last = 1'b1;
	end

	// layout filter and packing into queue slots
	always_comb begin
		e1 = f1_v && !(drop_q && f1.kind <= KIND_COMMENT && f1.err == ERR_NONE);
		e2 = f2_v && !(drop_q && f2.kind <= KIND_COMMENT && f2.err == ERR_NONE);
		push_n = adv ? (2'(e1) + 2'(e2)) : 2'd0;
		slot0  = e1 ? f1 : f2;
		slot0.last = !(e1 && e2);
		slot1  = f2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			qc_q   <= '0;
			len_q  <= '0;
			tlg_q  <= 1'b0;
			line_q <= '0;
			tl_q   <= '0;
			fc_q   <= '0;
			kc_q   <= KW_CAND_RESET;
			kp_q   <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			qc_q   <= qc_d;
			len_q  <= len_d;
			tlg_q  <= tlg_d;
			line_q <= line_d;
			tl_q   <= tl_d;
			fc_q   <= fc_d;
			kc_q   <= kc_d;
			kp_q   <= kp_d;
		end
	end

	// ---------------- result queue ----------------
	assign pop  = m_tvalid && m_tready;
	assign head = rq_mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + RQ_AW'(push_n);
			rd_q  <= rd_q + RQ_AW'(pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			rq_mem[wr_q] <= slot0;
		if (push_n == 2'd2)
			rq_mem[wr_q + RQ_AW'(1)] <= slot1;
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = TDATA_W'({head.err, head.line, head.len, head.lead, head.kind});
	assign m_tlast  = head.last;

endmodule

`default_nettype wire

@@ rtl/gft_checker.sv @@
// gft_checker: port-level assertions for grammar_file_tokenizer, bound to the top level.
// Depends on gft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gft_checker
	import gft_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int unsigned LINE_BITS   = LINE_BITS_DEF,
	localparam int unsigned FIELD_W = KIND_W + 8 + LENGTH_BITS + LINE_BITS + ERR_W,
	localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8,
	localparam int unsigned LEN_LSB = KIND_W + 8,
	localparam int unsigned ERR_LSB = KIND_W + 8 + LENGTH_BITS + LINE_BITS
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [TDATA_W-1:0] m_tdata,
	input wire logic               m_tlast
);

	logic [KIND_W-1:0]      kind;
	logic [7:0]             lead;
	logic [LENGTH_BITS-1:0] len;
	logic [ERR_W-1:0]       err;

	assign kind = m_tdata[KIND_W-1:0];
	assign lead = m_tdata[KIND_W +: 8];
	assign len  = m_tdata[LEN_LSB +: LENGTH_BITS];
	assign err  = m_tdata[ERR_LSB +: ERR_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> kind <= KIND_DOLLAR)
		else $error("token kind out of range");

	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == KIND_END |-> m_tlast && lead == 8'h00 && len == '0 &&
			err == ERR_NONE)
		else $error("malformed end token");

	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (err != ERR_OPEN_COMMENT || kind == KIND_COMMENT) &&
			(err != ERR_OPEN_QUOTE || kind == KIND_QUOTED))
		else $error("unterminated error on wrong token kind");

endmodule

bind grammar_file_tokenizer gft_checker #(
	.LENGTH_BITS(LENGTH_BITS),
	.LINE_BITS  (LINE_BITS)
) u_gft_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

`default_nettype wire

@@ dv/grammar_file_tokenizer_tb.sv @@
// grammar_file_tokenizer_tb: streams grammar source bytes and end markers through the
// tokenizer and checks each token word against an in-bench lexer model.
// Depends on gft_pkg and grammar_file_tokenizer.
`timescale 1ns / 1ps

module grammar_file_tokenizer_tb;
	import gft_pkg::*;

	localparam int TOKEN_W = 56;
	localparam int LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	localparam logic [KIND_W-1:0] KIND_TOKEN    = 5'd10;
	localparam logic [KIND_W-1:0] KIND_LEFT     = 5'd11;
	localparam logic [KIND_W-1:0] KIND_RIGHT    = 5'd12;
	localparam logic [KIND_W-1:0] KIND_NONASSOC = 5'd13;
	localparam logic [KIND_W-1:0] KIND_PREC     = 5'd14;
	localparam logic [KIND_W-1:0] KIND_TYPE     = 5'd15;
	localparam logic [KIND_W-1:0] KIND_UNION    = 5'd16;
	localparam logic [KIND_W-1:0] KIND_START    = 5'd17;
	localparam logic [KIND_W-1:0] KIND_EXPECT   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_PURE     = 5'd19;

	localparam logic [CFG_AW-1:0] ADDR_DROP_LAYOUT = 3'd0;
	localparam logic [CFG_AW-1:0] ADDR_MAX_LEN     = 3'd4;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  lead;
		logic [15:0] len;
		logic [23:0] line;
		logic [1:0]  err;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} src_word_t;

	class token_scoreboard;
		logic        drop_layout;
		logic [15:0] max_len;
		lex_mode_t   mode;
		logic [7:0]  quote_ch;
		logic [7:0]  first_ch;
		logic        dollar_pend;
		logic        too_long;
		logic [15:0] len_count;
		logic [23:0] line_count;
		logic [23:0] tok_line;
		logic [13:0] cand;
		logic [3:0]  kw_pos;
		string       kw_word [KW_COUNT];
		logic [4:0]  kw_kind [KW_COUNT];
		token_t      step_out [$];
		token_t      expected [$];
		int          errors;

		function new();
			kw_word = '{"token", "term", "left", "right", "nonassoc", "prec",
				"type", "union", "start", "expect", "pure_parser"};
			kw_kind = '{KIND_TOKEN, KIND_TOKEN, KIND_LEFT, KIND_RIGHT, KIND_NONASSOC,
				KIND_PREC, KIND_TYPE, KIND_UNION, KIND_START, KIND_EXPECT, KIND_PURE};
			drop_layout = 1'b0;
			max_len = 16'd50000;
			mode = MODE_IDLE;
			quote_ch = '0;
			first_ch = '0;
			dollar_pend = 1'b0;
			too_long = 1'b0;
			len_count = '0;
			line_count = '0;
			tok_line = '0;
			cand = '1;
			kw_pos = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
			if (addr == ADDR_DROP_LAYOUT)
				drop_layout = data[0];
			else if (addr == ADDR_MAX_LEN)
				max_len = data[15:0];
		endfunction

		function bit blank_ch(logic [7:0] b);
			return b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF;
		endfunction

		function bit digit_ch(logic [7:0] b);
			return b >= 8'h30 && b <= 8'h39;
		endfunction

		function bit word_ch(logic [7:0] b);
			return digit_ch(b) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)
				|| b == CH_US;
		endfunction

		function void push_token(logic [4:0] kind, logic [7:0] lead, logic [15:0] len,
			logic [23:0] line, logic [1:0] err);
			token_t t;
			if (drop_layout && kind <= KIND_COMMENT && err == ERR_NONE)
				return;
			if (step_out.size() >= 3)
				return;
			t.kind = kind;
			t.lead = lead;
			t.len = len;
			t.line = line;
			t.err = err;
			t.last = 1'b0;
			step_out.push_back(t);
		endfunction

		function void close_token(logic [4:0] kind, logic [1:0] err);
			if (err == ERR_NONE && too_long)
				err = ERR_TOO_LONG;
			push_token(kind, first_ch, len_count, tok_line, err);
			mode = MODE_IDLE;
		endfunction

		function void count_byte();
			if (len_count < max_len)
				len_count++;
			else
				too_long = 1'b1;
		endfunction

		function void open_token(logic [7:0] b, lex_mode_t m);
			first_ch = b;
			tok_line = line_count;
			len_count = '0;
			too_long = 1'b0;
			cand = '1;
			kw_pos = '0;
			mode = m;
			count_byte();
		endfunction

		function void track_keyword(logic [7:0] b);
			for (int i = 0; i < KW_COUNT; i++)
				if (kw_pos >= kw_word[i].len() || kw_word[i][kw_pos] != b)
					cand[i] = 1'b0;
			if (kw_pos < 15)
				kw_pos++;
		endfunction

		function logic [4:0] name_kind();
			if (first_ch == CH_PCT) begin
				for (int i = 0; i < KW_COUNT; i++)
					if (cand[i] && kw_word[i].len() == kw_pos)
						return kw_kind[i];
				return KIND_NAME;
			end
			return digit_ch(first_ch) ? KIND_NUMBER : KIND_NAME;
		endfunction

		function void lex_fresh(logic [7:0] b);
			if (blank_ch(b)) begin
				open_token(b, MODE_BLANK);
			end else if (b == CH_NL) begin
				open_token(b, MODE_IDLE);
				close_token(KIND_NEWLINE, ERR_NONE);
			end else if (b == CH_SLASH) begin
				open_token(b, MODE_SLASH);
			end else if (b == CH_PCT) begin
				open_token(b, MODE_PERCENT);
			end else if (b == CH_DOLLAR) begin
				if (dollar_pend) begin
					open_token(b, MODE_IDLE);
					dollar_pend = 1'b0;
					close_token(KIND_DOLLAR, ERR_NONE);
				end else begin
					open_token(b, MODE_DOLLAR);
				end
			end else if (word_ch(b)) begin
				open_token(b, MODE_WORD);
			end else if (b == CH_SQ || b == CH_DQ) begin
				quote_ch = b;
				open_token(b, MODE_QUOTE);
			end else begin
				open_token(b, MODE_IDLE);
				close_token(KIND_SINGLE, ERR_NONE);
			end
		endfunction

		// returns 1 when the byte ended a token and must be lexed again from idle
		function bit lex_byte(logic [7:0] b);
			case (mode)
				MODE_BLANK: begin
					if (blank_ch(b)) begin
						count_byte();
						return 1'b0;
					end
					close_token(KIND_SPACE, ERR_NONE);
					return 1'b1;
				end
				MODE_SLASH: begin
					if (b == CH_STAR) begin
						count_byte();
						mode = MODE_BLOCK;
						return 1'b0;
					end
					if (b == CH_SLASH) begin
						count_byte();
						mode = MODE_LINE;
						return 1'b0;
					end
					close_token(KIND_SINGLE, ERR_NONE);
					return 1'b1;
				end
				MODE_BLOCK: begin
					count_byte();
					if (b == CH_STAR)
						mode = MODE_BLOCK_STAR;
					return 1'b0;
				end
				MODE_BLOCK_STAR: begin
					count_byte();
					if (b == CH_SLASH)
						close_token(KIND_COMMENT, ERR_NONE);
					else if (b != CH_STAR)
						mode = MODE_BLOCK;
					return 1'b0;
				end
				MODE_LINE: begin
					count_byte();
					if (b == CH_NL)
						close_token(KIND_COMMENT, ERR_NONE);
					return 1'b0;
				end
				MODE_PERCENT: begin
					if (b == CH_PCT || b == CH_LCURL || b == CH_RCURL) begin
						count_byte();
						close_token(b == CH_PCT ? KIND_MARK :
							(b == CH_LCURL ? KIND_LCURL : KIND_RCURL), ERR_NONE);
						return 1'b0;
					end
					if (word_ch(b)) begin
						count_byte();
						track_keyword(b);
						mode = MODE_WORD;
						return 1'b0;
					end
					close_token(KIND_SINGLE, ERR_NONE);
					return 1'b1;
				end
				MODE_WORD: begin
					if (word_ch(b)) begin
						count_byte();
						if (first_ch == CH_PCT)
							track_keyword(b);
						return 1'b0;
					end
					close_token(name_kind(), ERR_NONE);
					return 1'b1;
				end
				MODE_DOLLAR: begin
					if (b == CH_DOLLAR) begin
						close_token(KIND_DOLLAR, ERR_NONE);
						dollar_pend = 1'b1;
						return 1'b1;
					end
					if (word_ch(b) && !digit_ch(b)) begin
						count_byte();
						mode = MODE_WORD;
						return 1'b0;
					end
					close_token(KIND_DOLLAR, ERR_NONE);
					return 1'b1;
				end
				MODE_QUOTE: begin
					count_byte();
					if (b == quote_ch)
						close_token(KIND_QUOTED, ERR_NONE);
					else if (b == CH_NL)
						close_token(KIND_QUOTED, ERR_OPEN_QUOTE);
					else if (b == CH_BSL)
						mode = MODE_QUOTE_ESC;
					return 1'b0;
				end
				MODE_QUOTE_ESC: begin
					count_byte();
					mode = MODE_QUOTE;
					return 1'b0;
				end
				default: begin
					mode = MODE_IDLE;
					lex_fresh(b);
					return 1'b0;
				end
			endcase
		endfunction

		function void flush_open();
			case (mode)
				MODE_BLANK: close_token(KIND_SPACE, ERR_NONE);
				MODE_SLASH: close_token(KIND_SINGLE, ERR_NONE);
				MODE_BLOCK, MODE_BLOCK_STAR: close_token(KIND_COMMENT, ERR_OPEN_COMMENT);
				MODE_LINE: close_token(KIND_COMMENT, ERR_NONE);
				MODE_PERCENT: close_token(KIND_SINGLE, ERR_NONE);
				MODE_WORD: close_token(name_kind(), ERR_NONE);
				MODE_DOLLAR: close_token(KIND_DOLLAR, ERR_NONE);
				MODE_QUOTE, MODE_QUOTE_ESC: close_token(KIND_QUOTED, ERR_OPEN_QUOTE);
				default: ;
			endcase
		endfunction

		function void note_word(src_word_t w);
			step_out.delete();
			if (w.eoi) begin
				flush_open();
				push_token(KIND_END, 8'h00, 16'h0000, line_count, ERR_NONE);
				mode = MODE_IDLE;
				dollar_pend = 1'b0;
			end else begin
				if (lex_byte(w.b))
					void'(lex_byte(w.b));
				if (w.b == CH_NL)
					line_count++;
			end
			if (step_out.size() > 0)
				step_out[step_out.size() - 1].last = 1'b1;
			foreach (step_out[i])
				expected.push_back(step_out[i]);
		endfunction

		function void check_token(logic [TOKEN_W-1:0] data, logic last_in);
			token_t got;
			token_t exp_t;
			got.kind = data[4:0];
			got.lead = data[12:5];
			got.len = data[28:13];
			got.line = data[52:29];
			got.err = data[54:53];
			got.last = last_in;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected token kind %0d lead %02h len %0d line %0d err %0d last %0d",
					$time, got.kind, got.lead, got.len, got.line, got.err, got.last);
				return;
			end
			exp_t = expected.pop_front();
			if (got !== exp_t) begin
				errors++;
				$display("%0t: token mismatch: expected kind %0d lead %02h len %0d line %0d err %0d last %0d",
					$time, exp_t.kind, exp_t.lead, exp_t.len, exp_t.line, exp_t.err, exp_t.last);
				$display("%0t:                 got kind %0d lead %02h len %0d line %0d err %0d last %0d",
					$time, got.kind, got.lead, got.len, got.line, got.err, got.last);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TOKEN_W-1:0]   m_tdata;
	logic                 m_tlast;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [CFG_AW-1:0]    paddr = '0;
	logic [CFG_DW-1:0]    pwdata = '0;
	logic [CFG_DW-1:0]    prdata;
	logic                 pready;

	token_scoreboard sb = new();
	src_word_t stim [$];
	string punct_set = ";:|,()<>=[]!#&*+-.?@^~";
	bit calm = 1'b0;
	int rx_wait = 0;
	int rx_hold = 0;
	int cycles = 0;

	grammar_file_tokenizer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// token receiver: random stalls per word, plus an optional long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			sb.check_token(m_tdata, m_tlast);
			rx_wait = calm ? 0 : $urandom_range(0, 5);
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		if (rx_hold > 0)
			rx_hold--;
		m_tready <= (rx_wait == 0) && (rx_hold == 0);
	end

	function automatic void put_char(logic [7:0] b);
		src_word_t w;
		w.b = b;
		w.eoi = 1'b0;
		stim.push_back(w);
	endfunction

	function automatic void put_end();
		src_word_t w;
		w.b = 8'($urandom_range(0, 255));
		w.eoi = 1'b1;
		stim.push_back(w);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 4))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_CR;
			3: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	function automatic logic [7:0] pick_word_char(bit lead);
		case ($urandom_range(lead ? 1 : 0, 3))
			0: return 8'h30 + 8'($urandom_range(0, 9));
			1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return 8'h41 + 8'($urandom_range(0, 25));
			default: return CH_US;
		endcase
	endfunction

	function automatic void add_random_token();
		int n;
		logic [7:0] q;
		string kw;
		n = $urandom_range(1, 6);
		case ($urandom_range(0, 15))
			0: repeat (n) put_char(pick_blank());
			1: put_char(CH_NL);
			2: begin
				put_text("/*");
				repeat (n - 1)
					case ($urandom_range(0, 4))
						0: put_char(CH_STAR);
						1: put_char(CH_NL);
						2: put_char(pick_blank());
						default: put_char(pick_word_char(1'b0));
					endcase
				if ($urandom_range(0, 1))
					put_char(CH_STAR);
				put_text("*/");
			end
			3: begin
				put_text("//");
				repeat (n) put_char($urandom_range(0, 3) ? pick_word_char(1'b0) : pick_blank());
				put_char(CH_NL);
			end
			4, 5: begin
				put_char($urandom_range(0, 2) ? pick_word_char(1'b1) : 8'h30 + 8'($urandom_range(0, 9)));
				repeat (n - 1) put_char(pick_word_char(1'b0));
				put_char(pick_blank());
			end
			6, 7, 8: begin
				kw = sb.kw_word[$urandom_range(0, KW_COUNT - 1)];
				put_char(CH_PCT);
				case ($urandom_range(0, 3))
					0: put_text(kw.substr(0, kw.len() - 2));
					1: begin
						put_text(kw);
						put_char(pick_word_char(1'b0));
					end
					default: put_text(kw);
				endcase
				if ($urandom_range(0, 1))
					put_char(pick_blank());
			end
			9: begin
				put_char(CH_PCT);
				case ($urandom_range(0, 3))
					0: put_char(CH_PCT);
					1: put_char(CH_LCURL);
					2: put_char(CH_RCURL);
					default: put_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
				endcase
			end
			10: begin
				put_char(CH_DOLLAR);
				case ($urandom_range(0, 4))
					0: put_char(CH_DOLLAR);
					1: put_char(8'h30 + 8'($urandom_range(0, 9)));
					2: repeat (n) put_char(pick_word_char(1'b1));
					3: put_char(8'h3C);
					default: put_char(pick_blank());
				endcase
			end
			11, 12: begin
				q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
				put_char(q);
				repeat (n - 1)
					case ($urandom_range(0, 5))
						0: begin
							put_char(CH_BSL);
							case ($urandom_range(0, 2))
								0: put_char(CH_NL);
								1: put_char(q);
								default: put_char(8'($urandom_range(0, 255)));
							endcase
						end
						1: put_char(q == CH_SQ ? CH_DQ : CH_SQ);
						2: put_char(pick_blank());
						default: put_char(pick_word_char(1'b0));
					endcase
				put_char($urandom_range(0, 5) ? q : CH_NL);
			end
			13: put_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
			14: put_char(8'($urandom_range(0, 255)));
			default: begin
				if ($urandom_range(0, 2) == 0)
					put_end();
				else
					put_char(CH_NL);
			end
		endcase
	endfunction

	task automatic send_word(input src_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w.b;
		s_tuser <= w.eoi;
		do @(posedge clk); while (!s_tready);
		sb.note_word(w);
	endtask

	task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(addr, data);
	endtask

	task automatic run_phase(input int n, input bit do_write, input logic drop,
		input logic [15:0] max_len, input bit quiet, input int hold);
		if (do_write) begin
			apb_write(ADDR_DROP_LAYOUT, {31'd0, drop});
			apb_write(ADDR_MAX_LEN, {16'd0, max_len});
		end
		calm = quiet;
		if (hold > 0)
			rx_hold = hold;
		while (stim.size() < n)
			add_random_token();
		while (stim.size() > 0)
			send_word(stim.pop_front());
		s_tvalid <= 1'b0;
		while (sb.expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, lone slash at end
		put_char(8'h00);
		put_char(8'hFF);
		put_char(CH_SLASH);
		put_end();
		// backslash-newline inside a quote, then quote left open at end
		put_char(CH_DQ);
		put_char("a");
		put_char(CH_BSL);
		put_char(CH_NL);
		put_end();
		// quote cut by newline
		put_char(CH_SQ);
		put_char("x");
		put_char(CH_NL);
		// open block comment, line comment, lone percent at end
		put_text("/*");
		put_end();
		put_text("//");
		put_end();
		put_char(CH_PCT);
		put_end();
		put_text("$$%%");

		run_phase(80, 1'b0, 1'b0, 16'd50000, 1'b0, 0);
		run_phase(60, 1'b1, 1'b1, 16'd1, 1'b1, 0);
		run_phase(50, 1'b1, 1'b0, 16'd0, 1'b0, 0);
		run_phase(60, 1'b1, 1'b1, 16'd65535, 1'b0, 0);
		run_phase(70, 1'b1, 1'b0, 16'($urandom_range(2, 6)), 1'b1, 300);

		if (sb.errors == 0 && sb.expected.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
